>>> hdl/assert_macros.svh
// Assertion macros for the RTL modules; bsst_back includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk_i, muted while rst_ni is low.
`define BSST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising edge of clk_i, reset included.
`define BSST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/bsst_pkg.sv
// Shared types and constants of the bounded set span tracker.
package bsst_pkg;

  localparam int unsigned VAL_W        = 32;
  localparam int unsigned CNT_W        = 11;
  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned MAX_CFG      = (1 << CNT_W) - 1;
  localparam int unsigned QUEUE_DEPTH  = 2;

  // Fewest held values for which the spans mean something.
  localparam logic [CNT_W-1:0] MIN_SPAN_COUNT = CNT_W'(2);

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    accept;
  } bsst_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } bsst_state_e;

endpackage

>>> hdl/bsst_fifo.sv
// Short item queue between the classifying front and the executing back.
module bsst_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bsst_pkg::bsst_item_t push_item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output bsst_pkg::bsst_item_t head_o
);
  import bsst_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);

  bsst_item_t             slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0]       fill_q, fill_d;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    bump = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (fill_q == FillW'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? bump(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? bump(rd_ptr_q) : rd_ptr_q;
    fill_d   = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + FillW'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> hdl/bsst_front.sv
// Front end: capacity register, input handshake and accept/reject decision.
module bsst_front #(
  parameter int unsigned CAPACITY = bsst_pkg::CAPACITY_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bsst_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [bsst_pkg::VAL_W-1:0] value_i,
  output logic                       push_o,
  output bsst_pkg::bsst_item_t       push_item_o,
  input  logic                       full_i
);
  import bsst_pkg::*;

  localparam int unsigned CapClip = (CAPACITY > MAX_CFG) ? MAX_CFG : CAPACITY;
  localparam logic [CNT_W-1:0] CapLimit = CNT_W'(CapClip);

  logic [CNT_W-1:0] capacity_q;
  logic [CNT_W-1:0] taken_q, taken_d;
  logic [CNT_W-1:0] limit;
  logic             room;

  // Clip the programmed capacity to the store depth.
  assign limit = (capacity_q > CapLimit) ? CapLimit : capacity_q;
  assign room  = (taken_q < limit);

  assign in_stall_o         = full_i;
  assign push_o             = in_valid_i && !full_i;
  assign push_item_o.value  = value_i;
  assign push_item_o.accept = room;

  assign taken_d = (push_o && room) ? taken_q + CNT_W'(1) : taken_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= '0;
      taken_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      taken_q <= taken_d;
    end
  end

endmodule

>>> hdl/bsst_back.sv
// Back end: value store, neighbor scan, running extremes and result register.
module bsst_back #(
  parameter int unsigned CAPACITY = bsst_pkg::CAPACITY_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  bsst_pkg::bsst_item_t       head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       status_o,
  output logic [bsst_pkg::CNT_W-1:0] count_o,
  output logic                       spans_valid_o,
  output logic [bsst_pkg::VAL_W-1:0] shortest_span_o,
  output logic [bsst_pkg::VAL_W-1:0] longest_span_o
);
  import bsst_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned AddrW = $clog2(CAPACITY);

  bsst_state_e state_q, state_d;

  logic [VAL_W-1:0]        store [CAPACITY];
  logic [VAL_W-1:0]        rdata_q;
  logic signed [VAL_W-1:0] x_q;
  logic                    acc_q;
  logic [CNT_W-1:0]        held_q;
  logic [CNT_W-1:0]        scan_idx_q;
  logic                    rd_vld_q;
  logic                    gap_vld_q;
  logic [VAL_W-1:0]        gap_q;
  logic [VAL_W-1:0]        min_gap_q;
  logic signed [VAL_W-1:0] smallest_q;
  logic signed [VAL_W-1:0] largest_q;

  logic             out_valid_q;
  logic             status_q;
  logic [CNT_W-1:0] count_q;
  logic             spans_valid_q;
  logic [VAL_W-1:0] shortest_q;
  logic [VAL_W-1:0] longest_q;

  logic             out_free;
  logic             scan_last;
  logic             rd_en;
  logic             load;
  logic [VAL_W:0]   diff_xr;
  logic [VAL_W:0]   diff_rx;
  logic [VAL_W-1:0] gap_d;
  logic [CNT_W-1:0] held_new;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign scan_last = (scan_idx_q == held_q - CNT_W'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          if (head_i.accept && (held_q != '0)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !gap_vld_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    pop_o = 1'b0;
    rd_en = 1'b0;
    load  = 1'b0;
    unique case (state_q)
      ST_IDLE:   pop_o = !empty_i;
      ST_SCAN:   rd_en = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: load  = out_free;
      default:   ;
    endcase
  end

  // Absolute difference in 33 bits; both directions side by side.
  assign diff_xr = {x_q[VAL_W-1], x_q} - {rdata_q[VAL_W-1], rdata_q};
  assign diff_rx = {rdata_q[VAL_W-1], rdata_q} - {x_q[VAL_W-1], x_q};
  assign gap_d   = diff_xr[VAL_W] ? diff_rx[VAL_W-1:0] : diff_xr[VAL_W-1:0];

  assign held_new = acc_q ? held_q + CNT_W'(1) : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      scan_idx_q  <= '0;
      rd_vld_q    <= 1'b0;
      gap_vld_q   <= 1'b0;
      min_gap_q   <= '1;
      smallest_q  <= '0;
      largest_q   <= '0;
      out_valid_q <= 1'b0;
      acc_q       <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_en;
      gap_vld_q <= rd_vld_q;
      if (pop_o) begin
        acc_q      <= head_i.accept;
        scan_idx_q <= '0;
        if (head_i.accept) begin
          if (held_q == '0) begin
            smallest_q <= head_i.value;
            largest_q  <= head_i.value;
          end else begin
            if (head_i.value < smallest_q) begin
              smallest_q <= head_i.value;
            end
            if (head_i.value > largest_q) begin
              largest_q <= head_i.value;
            end
          end
        end
      end else if (rd_en) begin
        scan_idx_q <= scan_idx_q + CNT_W'(1);
      end
      if (gap_vld_q && (gap_q < min_gap_q)) begin
        min_gap_q <= gap_q;
      end
      if (load) begin
        held_q <= held_new;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Value store: written when an accepted item retires, read during the scan.
  always_ff @(posedge clk_i) begin
    if (load && acc_q) begin
      store[AddrW'(held_q)] <= x_q;
    end
    if (rd_en) begin
      rdata_q <= store[AddrW'(scan_idx_q)];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      x_q <= head_i.value;
    end
    gap_q <= gap_d;
    if (load) begin
      status_q      <= acc_q ? STATUS_OK : STATUS_FULL;
      count_q       <= held_new;
      spans_valid_q <= (held_new >= MIN_SPAN_COUNT);
      shortest_q    <= (held_new >= MIN_SPAN_COUNT) ? min_gap_q : '0;
      longest_q     <= (held_new >= MIN_SPAN_COUNT) ? VAL_W'(largest_q - smallest_q) : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign count_o         = count_q;
  assign spans_valid_o   = spans_valid_q;
  assign shortest_span_o = shortest_q;
  assign longest_span_o  = longest_q;

  `BSST_ASSERT(a_held_in_range, held_q <= CNT_W'(CAPACITY > MAX_CFG ? MAX_CFG : CAPACITY), "held count beyond store depth")
  `BSST_ASSERT(a_scan_below_held, (state_q == ST_SCAN) |-> (scan_idx_q < held_q), "scan reads past held values")
  `BSST_ASSERT(a_gap_before_finish, gap_vld_q |-> (state_q == ST_SCAN || state_q == ST_DRAIN), "gap still in flight at retire")
  `BSST_ASSERT_ALWAYS(a_extremes_ordered, (held_q != '0) |-> (smallest_q <= largest_q), "smallest above largest")

endmodule

>>> hdl/bounded_set_span_tracker.sv
// Top level of the bounded set span tracker: front, queue and back joined.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ----------------------------------------
//  in        slave      in_valid_i / in_stall_o    value_i
//  out       master     out_valid_o / out_stall_i  status_o count_o spans_valid_o
//                                                  shortest_span_o longest_span_o
//  cfg       slave      cfg_we_i                   cfg_wdata_i (capacity)
//
// An accepted item with values already held passes through the back end as a pop, one
// store read per held value, a drain of the read and gap stages, and a retire; a rejected
// item, or the first value, goes from pop straight to retire.
// The single-port value store, read once per cycle, sets the pace of the scan.
// Reset clears the count, extremes, shortest span (all ones) and capacity; store contents
// are not cleared, only entries below the held count are read.
// A two-entry queue lets the input side keep taking items while the back end scans or
// while a finished result waits on out_stall_i.
module bounded_set_span_tracker #(
  parameter int unsigned CAPACITY = bsst_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bsst_pkg::CNT_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [bsst_pkg::VAL_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              status_o,
  output logic [bsst_pkg::CNT_W-1:0]        count_o,
  output logic                              spans_valid_o,
  output logic [bsst_pkg::VAL_W-1:0]        shortest_span_o,
  output logic [bsst_pkg::VAL_W-1:0]        longest_span_o
);
  import bsst_pkg::*;

  logic       push;
  bsst_item_t push_item;
  logic       full;
  logic       pop;
  logic       empty;
  bsst_item_t head;

  // Classify each item as it arrives: the front keeps its own count of accepted
  // items, so it knows whether the store will have room when the item reaches the back.
  bsst_front #(
    .CAPACITY(CAPACITY)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .push_o     (push),
    .push_item_o(push_item),
    .full_i     (full)
  );

  // Hold classified items until the back end is free.
  bsst_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  // Scan held values for the nearest neighbor gap, store the value, report.
  bsst_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .count_o        (count_o),
    .spans_valid_o  (spans_valid_o),
    .shortest_span_o(shortest_span_o),
    .longest_span_o (longest_span_o)
  );

endmodule
